[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbd_pkg
// shared types, address map and helpers of the sub-cpu bus decoder
// ----------------------------------------------------------------------------
package sbd_pkg;

   localparam int unsigned PROGRAM_WORDS_DEF = 262144;
   localparam int unsigned SHARED_WORDS_DEF  = 131072;
   localparam int unsigned IRQ_LEVELS_DEF    = 6;
   localparam int unsigned CPU_CLOCK_DIV_DEF = 4;
   localparam int unsigned SAMPLE_DIV_DEF    = 384;

   localparam int unsigned PROG_IDX_W   = 18;
   localparam int unsigned SHARED_IDX_W = 17;

   // word addresses of the gate-array registers
   localparam logic [22:0] WA_MODE   = 23'(24'hFF8002 >> 1);
   localparam logic [22:0] WA_ID     = 23'(24'hFF8004 >> 1);
   localparam logic [22:0] WA_FLAG   = 23'(24'hFF800E >> 1);
   localparam logic [22:0] WA_TIMER  = 23'(24'hFF8030 >> 1);
   localparam logic [22:0] WA_IRQ    = 23'(24'hFF8032 >> 1);
   localparam logic [22:0] WA_TRACE  = 23'(24'hFF8066 >> 1);
   localparam logic [19:0] WA_CMD_HI    = 20'(24'hFF8010 >> 4);
   localparam logic [19:0] WA_STATUS_HI = 20'(24'hFF8020 >> 4);

   localparam logic [15:0] ID_WORD  = 16'h4000;
   localparam logic [18:0] TIMER_MAX = 19'h7FFFF;

   typedef enum logic [2:0] {
      OP_SUB_READ     = 3'd0,
      OP_SUB_WRITE    = 3'd1,
      OP_MAIN_CMD     = 3'd2,
      OP_MAIN_RELEASE = 3'd3,
      OP_MAIN_FLAG    = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      REG_NONE,
      REG_MODE,
      REG_ID,
      REG_FLAG,
      REG_CMD,
      REG_STATUS,
      REG_TIMER,
      REG_IRQ,
      REG_TRACE
   } reg_sel_type;

   typedef struct packed {
      logic half_bank;
      logic released;
      logic ret;
   } mode_type;

   typedef struct packed {
      logic                    prog_en;
      logic                    shared_en;
      logic                    write;
      logic [PROG_IDX_W-1:0]   prog_index;
      logic [SHARED_IDX_W-1:0] shared_index;
      reg_sel_type             reg_sel;
      logic [2:0]              reg_index;
   } decode_type;

   // remainder of an 18-bit index by a modulus of at least 1024
   function automatic logic [17:0] fold_index(input logic [17:0] value,
                                              input logic [18:0] modulus);
      logic [25:0] rem;
      logic [25:0] step;
      rem = 26'(value);
      for (int k = 7; k >= 0; k--) begin
         step = 26'(modulus) << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[17:0];
   endfunction

endpackage

[hw/rtl/sbd_ram.sv]
// ----------------------------------------------------------------------------
// sbd_ram
// single-port word memory with byte write enables and registered read
// ----------------------------------------------------------------------------
module sbd_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [1:0]    be,
   input  logic [AW-1:0] addr,
   input  logic [15:0]   wdata,
   output logic [15:0]   rdata
);

   logic [15:0] ram_ff [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            if (be[1]) begin
               ram_ff[addr][15:8] <= wdata[15:8];
            end
            if (be[0]) begin
               ram_ff[addr][7:0] <= wdata[7:0];
            end
         end else begin
            rdata_ff <= ram_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/sbd_decode.sv]
// ----------------------------------------------------------------------------
// sbd_decode
// address decode of one bus beat into memory index and register select
// ----------------------------------------------------------------------------
module sbd_decode import sbd_pkg::*; #(
   parameter int unsigned PROGRAM_WORDS = PROGRAM_WORDS_DEF,
   parameter int unsigned SHARED_WORDS  = SHARED_WORDS_DEF
) (
   input  op_type      opcode,
   input  logic [22:0] word_address,
   input  mode_type    mode,
   output decode_type  dec
);

   logic mem_op;
   logic prog_hit;
   logic whole_hit;
   logic half_hit;
   logic [SHARED_IDX_W-1:0] shared_raw;
   logic [17:0] shared_fold;

   assign mem_op    = (opcode == OP_SUB_READ) || (opcode == OP_SUB_WRITE);
   assign prog_hit  = (word_address[22:18] == 5'b00000);
   assign whole_hit = (word_address[22:17] == 6'b000010);
   assign half_hit  = (word_address[22:16] == 7'b0000110);

   assign shared_raw  = mode.half_bank ? {word_address[15:0], ~mode.ret}
                                       : word_address[16:0];
   assign shared_fold = fold_index({1'b0, shared_raw}, 19'(SHARED_WORDS));

   always_comb begin
      dec.prog_en      = mem_op && prog_hit;
      dec.shared_en    = mem_op && ((whole_hit && !mode.half_bank && mode.released) ||
                                    (half_hit && mode.half_bank));
      dec.write        = (opcode == OP_SUB_WRITE);
      dec.prog_index   = fold_index(word_address[17:0], 19'(PROGRAM_WORDS));
      dec.shared_index = shared_fold[SHARED_IDX_W-1:0];
      dec.reg_index    = word_address[2:0];
      if (word_address == WA_MODE) begin
         dec.reg_sel = REG_MODE;
      end else if (word_address == WA_ID) begin
         dec.reg_sel = REG_ID;
      end else if (word_address == WA_FLAG) begin
         dec.reg_sel = REG_FLAG;
      end else if (word_address[22:3] == WA_CMD_HI) begin
         dec.reg_sel = REG_CMD;
      end else if (word_address[22:3] == WA_STATUS_HI) begin
         dec.reg_sel = REG_STATUS;
      end else if (word_address == WA_TIMER) begin
         dec.reg_sel = REG_TIMER;
      end else if (word_address == WA_IRQ) begin
         dec.reg_sel = REG_IRQ;
      end else if (word_address == WA_TRACE) begin
         dec.reg_sel = REG_TRACE;
      end else begin
         dec.reg_sel = REG_NONE;
      end
   end

endmodule

[hw/rtl/sbd_regs.sv]
// ----------------------------------------------------------------------------
// sbd_regs
// gate-array register file: mode, flag, command and status words, irq, timer
// ----------------------------------------------------------------------------
module sbd_regs import sbd_pkg::*; #(
   parameter int unsigned IRQ_LEVELS    = IRQ_LEVELS_DEF,
   parameter int unsigned CPU_CLOCK_DIV = CPU_CLOCK_DIV_DEF,
   parameter int unsigned SAMPLE_DIV    = SAMPLE_DIV_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  op_type      opcode,
   input  decode_type  dec,
   input  logic        upper_byte_enable,
   input  logic        lower_byte_enable,
   input  logic [15:0] write_data,
   output mode_type    mode,
   output logic [15:0] reg_rdata,
   output logic [5:0]  irq_enables,
   output logic        irq1_flag,
   output logic [18:0] timer_period
);

   localparam int unsigned TIMER_FACTOR = CPU_CLOCK_DIV * SAMPLE_DIV;
   localparam int unsigned FACTOR_W     = $clog2(TIMER_FACTOR + 1);
   localparam int unsigned PROD_W       = FACTOR_W + 9;
   localparam logic [5:0]  IRQ_KEEP     = 6'(((1 << IRQ_LEVELS) - 1) & 'h3F);

   mode_type    mode_ff, mode_in;
   logic [15:0] flag_ff, flag_in;
   logic [15:0] cmd_ff [8];
   logic [15:0] cmd_in [8];
   logic [15:0] status_ff [8];
   logic [15:0] status_in [8];
   logic [5:0]  irq_en_ff, irq_en_in;
   logic        irq1_ff, irq1_in;
   logic [18:0] timer_ff, timer_in;
   logic [15:0] mask;
   logic [PROD_W-1:0] product;
   logic        sub_wr;

   assign mask    = {{8{upper_byte_enable}}, {8{lower_byte_enable}}};
   assign sub_wr  = accept && (opcode == OP_SUB_WRITE);
   assign product = PROD_W'({1'b0, write_data[7:0]} + 9'd1) * PROD_W'(TIMER_FACTOR);

   always_comb begin
      mode_in   = mode_ff;
      flag_in   = flag_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      irq_en_in = irq_en_ff;
      irq1_in   = irq1_ff;
      timer_in  = timer_ff;
      if (sub_wr) begin
         case (dec.reg_sel)
            REG_MODE: begin
               if (lower_byte_enable) begin
                  mode_in.half_bank = write_data[2];
                  if (write_data[0] || write_data[2]) begin
                     mode_in.released = 1'b0;
                     mode_in.ret      = write_data[0];
                  end
               end
            end
            REG_FLAG: begin
               if (lower_byte_enable) begin
                  flag_in[7:0] = write_data[7:0];
               end
            end
            REG_STATUS: begin
               status_in[dec.reg_index] = (status_ff[dec.reg_index] & ~mask) |
                                          (write_data & mask);
            end
            REG_TIMER: begin
               if (lower_byte_enable) begin
                  if (write_data[7:0] == 8'd0) begin
                     timer_in = '0;
                  end else if (32'(product) > 32'(TIMER_MAX)) begin
                     timer_in = TIMER_MAX;
                  end else begin
                     timer_in = 19'(product);
                  end
               end
            end
            REG_IRQ: begin
               if (lower_byte_enable) begin
                  irq_en_in = write_data[6:1] & IRQ_KEEP;
                  if (!irq_en_in[0]) begin
                     irq1_in = 1'b0;
                  end
               end
            end
            REG_TRACE: begin
               if (irq_en_ff[0]) begin
                  irq1_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (accept) begin
         case (opcode)
            OP_MAIN_CMD: begin
               cmd_in[dec.reg_index] = (cmd_ff[dec.reg_index] & ~mask) |
                                       (write_data & mask);
            end
            OP_MAIN_RELEASE: begin
               mode_in.released = 1'b1;
            end
            OP_MAIN_FLAG: begin
               flag_in[15:8] = write_data[15:8];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         flag_ff   <= '0;
         irq_en_ff <= '0;
         irq1_ff   <= 1'b0;
         timer_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            cmd_ff[i]    <= '0;
            status_ff[i] <= '0;
         end
      end else begin
         mode_ff   <= mode_in;
         flag_ff   <= flag_in;
         irq_en_ff <= irq_en_in;
         irq1_ff   <= irq1_in;
         timer_ff  <= timer_in;
         cmd_ff    <= cmd_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      case (dec.reg_sel)
         REG_MODE:   reg_rdata = {13'd0, mode_ff.half_bank, mode_ff.released, mode_ff.ret};
         REG_ID:     reg_rdata = ID_WORD;
         REG_FLAG:   reg_rdata = flag_ff;
         REG_CMD:    reg_rdata = cmd_ff[dec.reg_index];
         REG_STATUS: reg_rdata = status_ff[dec.reg_index];
         REG_IRQ:    reg_rdata = {9'd0, irq_en_ff, 1'b0};
         default:    reg_rdata = '0;
      endcase
   end

   assign mode         = mode_ff;
   assign irq_enables  = irq_en_ff;
   assign irq1_flag    = irq1_ff;
   assign timer_period = timer_ff;

endmodule

[hw/rtl/sub_cpu_bus_decoder_top.sv]
// ----------------------------------------------------------------------------
// sub_cpu_bus_decoder_top: a response beat is valid in the cycle after its request beat is accepted
// throughput is one beat per cycle unless stalled, set by the single read-or-write port of each ram
// a stalled response beat holds the request side until it is taken
// reset clears all registers but the read-data ones; program and word ram contents are undefined until written
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sub_cpu_bus_decoder_top import sbd_pkg::*; #(
   parameter int unsigned PROGRAM_WORDS = PROGRAM_WORDS_DEF,
   parameter int unsigned SHARED_WORDS  = SHARED_WORDS_DEF,
   parameter int unsigned IRQ_LEVELS    = IRQ_LEVELS_DEF,
   parameter int unsigned CPU_CLOCK_DIV = CPU_CLOCK_DIV_DEF,
   parameter int unsigned SAMPLE_DIV    = SAMPLE_DIV_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [22:0] req_word_address,
   input  logic        req_upper_byte_enable,
   input  logic        req_lower_byte_enable,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic [5:0]  rsp_irq_enable_mask,
   output logic        rsp_level1_pending,
   output logic [18:0] rsp_timer_reload
);

   localparam int unsigned PROG_AW   = $clog2(PROGRAM_WORDS);
   localparam int unsigned SHARED_AW = $clog2(SHARED_WORDS);

   op_type      op;
   decode_type  dec;
   mode_type    mode;
   logic        accept;
   logic [15:0] reg_rdata;
   logic [15:0] prog_q;
   logic [15:0] shared_q;
   logic [1:0]  be;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        prog_rd_ff, prog_rd_in;
   logic        shared_rd_ff, shared_rd_in;
   logic [15:0] rd_reg_ff, rd_reg_in;

   assign op        = op_type'(req_opcode);
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign be        = {req_upper_byte_enable, req_lower_byte_enable};

   sbd_decode #(
      .PROGRAM_WORDS(PROGRAM_WORDS),
      .SHARED_WORDS (SHARED_WORDS)
   ) u_decode (
      .opcode      (op),
      .word_address(req_word_address),
      .mode        (mode),
      .dec         (dec)
   );

   sbd_regs #(
      .IRQ_LEVELS   (IRQ_LEVELS),
      .CPU_CLOCK_DIV(CPU_CLOCK_DIV),
      .SAMPLE_DIV   (SAMPLE_DIV)
   ) u_regs (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .opcode           (op),
      .dec              (dec),
      .upper_byte_enable(req_upper_byte_enable),
      .lower_byte_enable(req_lower_byte_enable),
      .write_data       (req_write_data),
      .mode             (mode),
      .reg_rdata        (reg_rdata),
      .irq_enables      (rsp_irq_enable_mask),
      .irq1_flag        (rsp_level1_pending),
      .timer_period     (rsp_timer_reload)
   );

   sbd_ram #(
      .DEPTH(PROGRAM_WORDS)
   ) u_prog_ram (
      .clock(clock),
      .en   (accept && dec.prog_en),
      .we   (dec.write),
      .be   (be),
      .addr (dec.prog_index[PROG_AW-1:0]),
      .wdata(req_write_data),
      .rdata(prog_q)
   );

   sbd_ram #(
      .DEPTH(SHARED_WORDS)
   ) u_shared_ram (
      .clock(clock),
      .en   (accept && dec.shared_en),
      .we   (dec.write),
      .be   (be),
      .addr (dec.shared_index[SHARED_AW-1:0]),
      .wdata(req_write_data),
      .rdata(shared_q)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      prog_rd_in   = prog_rd_ff && rsp_valid_in;
      shared_rd_in = shared_rd_ff && rsp_valid_in;
      rd_reg_in    = rd_reg_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         prog_rd_in   = dec.prog_en && !dec.write;
         shared_rd_in = dec.shared_en && !dec.write;
         rd_reg_in    = (op == OP_SUB_READ) ? reg_rdata : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prog_rd_ff   <= 1'b0;
         shared_rd_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         prog_rd_ff   <= prog_rd_in;
         shared_rd_ff <= shared_rd_in;
      end
      rd_reg_ff <= rd_reg_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = prog_rd_ff ? prog_q : (shared_rd_ff ? shared_q : rd_reg_ff);

   `ASSERT_IMPLIES(a_one_ram_src, clock, reset, 1'b1, $onehot0({prog_rd_ff, shared_rd_ff}))
   `ASSERT_IMPLIES(a_ram_src_valid, clock, reset, prog_rd_ff || shared_rd_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_accept_rsp, clock, reset, accept, rsp_valid_ff)
   `ASSERT_IMPLIES(a_l1_enabled, clock, reset, rsp_level1_pending, rsp_irq_enable_mask[0])

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: sub-cpu bus decoder
// drives sub-side and main-side bus beats through the valid/stall request
// channel, predicts each response beat from a local copy of the decoder
// state and checks every field of the response in order
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sbd_pkg::*;

   localparam logic [22:0] WA_WHOLE_BASE = 23'h040000;
   localparam logic [22:0] WA_HALF_BASE  = 23'h060000;
   localparam logic [22:0] WA_HALF_END   = 23'h070000;
   localparam logic [22:0] WA_PCM_BASE   = 23'h7F8000;
   localparam logic [22:0] WA_REG_BASE   = 23'h7FC000;
   localparam logic [22:0] WA_TOP        = 23'h7FFFFF;
   localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
   localparam int unsigned TIMER_STEP = CPU_CLOCK_DIV_DEF * SAMPLE_DIV_DEF;
   localparam logic [5:0]  IRQ_KEEP = 6'(((1 << IRQ_LEVELS_DEF) - 1) & 'h3F);
   localparam int          SHARED_KEY_BASE = 1 << 20;
   localparam int unsigned IDLE_PCT = 26;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [22:0] word_address;
      logic        upper_be;
      logic        lower_be;
      logic [15:0] write_data;
   } bus_beat_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [5:0]  irq_mask;
      logic        level1;
      logic [18:0] timer;
   } bus_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [22:0] req_word_address = '0;
   logic        req_upper_byte_enable = 1'b0;
   logic        req_lower_byte_enable = 1'b0;
   logic [15:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_read_data;
   logic [5:0]  rsp_irq_enable_mask;
   logic        rsp_level1_pending;
   logic [18:0] rsp_timer_reload;

   // decoder state as predicted
   logic [15:0] mem_words [int];
   logic [1:0]  mem_bytes [int];
   logic        half_mode = 1'b0;
   logic        released = 1'b0;
   logic        ret_bit = 1'b0;
   logic [15:0] flag_word = '0;
   logic [15:0] cmd_words [8] = '{default: '0};
   logic [15:0] status_words [8] = '{default: '0};
   logic [5:0]  irq_en = '0;
   logic        irq1 = 1'b0;
   logic [18:0] timer_period = '0;

   bus_status_type expected_status [$];
   bit          steady = 1'b0;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;

   sub_cpu_bus_decoder_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_word_address      (req_word_address),
      .req_upper_byte_enable (req_upper_byte_enable),
      .req_lower_byte_enable (req_lower_byte_enable),
      .req_write_data        (req_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_read_data         (rsp_read_data),
      .rsp_irq_enable_mask   (rsp_irq_enable_mask),
      .rsp_level1_pending    (rsp_level1_pending),
      .rsp_timer_reload      (rsp_timer_reload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ram word reached by a sub access in the current layout
   function automatic bit ram_key(input logic [22:0] wa, output int key);
      key = 0;
      if (wa < WA_WHOLE_BASE) begin
         key = int'(wa) % int'(PROGRAM_WORDS_DEF);
         return 1'b1;
      end
      if (wa < WA_HALF_BASE) begin
         if (half_mode || !released) return 1'b0;
         key = SHARED_KEY_BASE + int'(wa & 23'h1FFFF) % int'(SHARED_WORDS_DEF);
         return 1'b1;
      end
      if (wa < WA_HALF_END) begin
         if (!half_mode) return 1'b0;
         key = SHARED_KEY_BASE
             + (int'(wa & 23'h0FFFF) * 2 + 1 - int'(ret_bit)) % int'(SHARED_WORDS_DEF);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit read_is_defined(input logic [22:0] wa);
      int key;
      if (!ram_key(wa, key)) return 1'b1;
      return mem_bytes.exists(key) && mem_bytes[key] == 2'b11;
   endfunction

   function automatic logic [15:0] merge_word(input logic [15:0] old, input logic [15:0] data,
                                              input logic [15:0] mask);
      return (old & ~mask) | (data & mask);
   endfunction

   task automatic predict_access(input bus_beat_type b);
      logic [22:0] wa;
      logic [15:0] mask;
      logic [15:0] rd;
      logic [7:0]  low;
      int          key;
      bit          hit;
      int unsigned product;
      wa = b.word_address;
      mask = {{8{b.upper_be}}, {8{b.lower_be}}};
      low = b.write_data[7:0];
      rd = '0;
      hit = ram_key(wa, key);
      case (b.opcode)
         OP_SUB_READ: begin
            if (hit) rd = mem_words[key];
            else if (wa == WA_MODE) rd = {13'b0, half_mode, released, ret_bit};
            else if (wa == WA_ID) rd = ID_WORD;
            else if (wa == WA_FLAG) rd = flag_word;
            else if (wa[22:3] == WA_CMD_HI) rd = cmd_words[wa[2:0]];
            else if (wa[22:3] == WA_STATUS_HI) rd = status_words[wa[2:0]];
            else if (wa == WA_IRQ) rd = {9'b0, irq_en, 1'b0};
         end
         OP_SUB_WRITE: begin
            if (hit) begin
               mem_words[key] = merge_word(mem_words.exists(key) ? mem_words[key] : '0,
                                           b.write_data, mask);
               mem_bytes[key] = (mem_bytes.exists(key) ? mem_bytes[key] : 2'b00)
                              | {b.upper_be, b.lower_be};
            end else if (wa == WA_MODE) begin
               if (b.lower_be) begin
                  half_mode = b.write_data[2];
                  if (b.write_data[0] || half_mode) begin
                     released = 1'b0;
                     ret_bit = b.write_data[0];
                  end
               end
            end else if (wa == WA_FLAG) begin
               if (b.lower_be) flag_word[7:0] = low;
            end else if (wa[22:3] == WA_STATUS_HI) begin
               status_words[wa[2:0]] = merge_word(status_words[wa[2:0]], b.write_data, mask);
            end else if (wa == WA_TIMER) begin
               if (b.lower_be) begin
                  product = (low == 8'd0) ? 0 : (32'(low) + 1) * TIMER_STEP;
                  timer_period = (product > TIMER_MAX) ? TIMER_MAX : product[18:0];
               end
            end else if (wa == WA_IRQ) begin
               if (b.lower_be) begin
                  irq_en = b.write_data[6:1] & IRQ_KEEP;
                  if (!irq_en[0]) irq1 = 1'b0;
               end
            end else if (wa == WA_TRACE) begin
               if (irq_en[0]) irq1 = 1'b1;
            end
         end
         OP_MAIN_CMD: cmd_words[wa[2:0]] = merge_word(cmd_words[wa[2:0]], b.write_data, mask);
         OP_MAIN_RELEASE: released = 1'b1;
         OP_MAIN_FLAG: flag_word[15:8] = b.write_data[15:8];
         default: ;
      endcase
      expected_status.push_back('{rd, irq_en, irq1, timer_period});
   endtask

   function automatic bus_beat_type make_beat(input logic [2:0] op, input logic [22:0] wa,
                                              input logic ube, input logic lbe,
                                              input logic [15:0] data);
      return '{op, wa, ube, lbe, data};
   endfunction

   // never read a ram word that has not been fully written
   task automatic send_beat(input bus_beat_type b);
      int unsigned gap;
      if (b.opcode == OP_SUB_READ && !read_is_defined(b.word_address)) begin
         b.opcode = OP_SUB_WRITE;
         b.upper_be = 1'b1;
         b.lower_be = 1'b1;
      end
      gap = 0;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= b.opcode;
      req_word_address <= b.word_address;
      req_upper_byte_enable <= b.upper_be;
      req_lower_byte_enable <= b.lower_be;
      req_write_data <= b.write_data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_access(b);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   function automatic logic [22:0] random_address();
      int unsigned pick;
      logic [22:0] o;
      bit          top;
      pick = $urandom_range(0, 99);
      o = 23'($urandom_range(0, 15));
      top = 1'($urandom_range(0, 1));
      if (pick < 28) return top ? 23'h03FFFF - o : o;
      if (pick < 46) return WA_WHOLE_BASE + (top ? 23'h01FFFF - o : o);
      if (pick < 64) return WA_HALF_BASE + (top ? 23'h00FFFF - o : o);
      if (pick < 90) begin
         case ($urandom_range(0, 9))
            0: return WA_MODE;
            1: return WA_ID;
            2: return WA_FLAG;
            3: return {WA_CMD_HI, 3'($urandom_range(0, 7))};
            4: return {WA_STATUS_HI, 3'($urandom_range(0, 7))};
            5: return WA_TIMER;
            6: return WA_IRQ;
            7: return WA_TRACE;
            default: return WA_REG_BASE + 23'($urandom_range(0, 63));
         endcase
      end
      if (pick < 94) return WA_PCM_BASE + 23'($urandom_range(0, 16'h3FFF));
      return 23'($urandom);
   endfunction

   function automatic bus_beat_type random_beat();
      bus_beat_type b;
      int unsigned  pick;
      b.word_address = random_address();
      b.write_data = 16'($urandom);
      b.upper_be = 1'b1;
      b.lower_be = 1'b1;
      if ($urandom_range(0, 99) < 40) begin
         b.upper_be = 1'($urandom_range(0, 1));
         b.lower_be = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 36) b.opcode = OP_SUB_READ;
      else if (pick < 72) b.opcode = OP_SUB_WRITE;
      else if (pick < 82) b.opcode = OP_MAIN_CMD;
      else if (pick < 88) b.opcode = OP_MAIN_RELEASE;
      else if (pick < 95) b.opcode = OP_MAIN_FLAG;
      else b.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      return b;
   endfunction

   task automatic test_reset_values();
      send_beat(make_beat(OP_SUB_READ, WA_MODE, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_READ, WA_FLAG, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_READ, WA_IRQ, 1'b1, 1'b1, '0));
   endtask

   task automatic test_memory_map();
      send_beat(make_beat(OP_SUB_WRITE, 23'h000000, 1'b1, 1'b1, 16'hFFFF));
      send_beat(make_beat(OP_SUB_WRITE, 23'h03FFFF, 1'b1, 1'b1, 16'h0000));
      send_beat(make_beat(OP_SUB_READ, 23'h000000, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_READ, 23'h03FFFF, 1'b1, 1'b1, '0));
      // word ram not yet released
      send_beat(make_beat(OP_SUB_WRITE, WA_WHOLE_BASE, 1'b1, 1'b1, 16'h1357));
      send_beat(make_beat(OP_SUB_READ, WA_WHOLE_BASE, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_MAIN_RELEASE, '0, 1'b0, 1'b0, '0));
      send_beat(make_beat(OP_SUB_WRITE, 23'h05FFFF, 1'b1, 1'b1, 16'hA5C3));
      send_beat(make_beat(OP_SUB_READ, 23'h05FFFF, 1'b1, 1'b1, '0));
      // half-bank layout with ret set
      send_beat(make_beat(OP_SUB_WRITE, WA_MODE, 1'b0, 1'b1, 16'h0005));
      send_beat(make_beat(OP_SUB_WRITE, 23'h06FFFF, 1'b1, 1'b1, 16'h1234));
      send_beat(make_beat(OP_SUB_READ, 23'h06FFFF, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_READ, 23'h05FFFF, 1'b1, 1'b1, '0));
   endtask

   task automatic test_registers();
      send_beat(make_beat(OP_SUB_WRITE, WA_FLAG, 1'b1, 1'b1, 16'h55AB));
      send_beat(make_beat(OP_MAIN_FLAG, '0, 1'b0, 1'b0, 16'hCD00));
      send_beat(make_beat(OP_SUB_READ, WA_FLAG, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_MAIN_CMD, WA_TOP, 1'b1, 1'b0, 16'hBEEF));
      send_beat(make_beat(OP_SUB_READ, {WA_CMD_HI, 3'd7}, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_WRITE, {WA_STATUS_HI, 3'd3}, 1'b1, 1'b0, 16'hF00D));
      send_beat(make_beat(OP_SUB_READ, {WA_STATUS_HI, 3'd3}, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_WRITE, WA_TIMER, 1'b0, 1'b1, 16'h00FF));
      send_beat(make_beat(OP_SUB_WRITE, WA_TIMER, 1'b1, 1'b1, 16'hFF00));
      send_beat(make_beat(OP_SUB_WRITE, WA_IRQ, 1'b0, 1'b1, 16'hFFFE));
      send_beat(make_beat(OP_SUB_WRITE, WA_TRACE, 1'b1, 1'b1, 16'h0000));
      // no byte enable leaves the mask alone
      send_beat(make_beat(OP_SUB_WRITE, WA_IRQ, 1'b0, 1'b0, 16'h0000));
      send_beat(make_beat(OP_SUB_WRITE, WA_IRQ, 1'b1, 1'b1, 16'h0000));
      send_beat(make_beat(OP_SUB_READ, WA_ID, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_READ, WA_TOP, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SUB_READ, WA_PCM_BASE, 1'b1, 1'b1, '0));
      send_beat(make_beat(OP_SPARE_LAST, WA_TOP, 1'b1, 1'b1, 16'hFFFF));
   endtask

   task automatic test_random_traffic(input int unsigned count);
      int unsigned sent;
      bit          half;
      logic [15:0] data;
      sent = 0;
      while (sent < count) begin
         steady = (sent >= count / 3) && (sent < count / 3 + 250);
         // most of the time set up a layout, then a burst of random beats
         if ($urandom_range(0, 99) < 80) begin
            half = 1'($urandom_range(0, 1));
            data = 16'($urandom);
            data[2] = half;
            data[0] = half ? 1'($urandom_range(0, 1)) : 1'b0;
            send_beat(make_beat(OP_SUB_WRITE, WA_MODE, 1'($urandom_range(0, 1)), 1'b1, data));
            sent++;
            if (!half && $urandom_range(0, 9) != 0) begin
               send_beat(make_beat(OP_MAIN_RELEASE, random_address(), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 16'($urandom)));
               sent++;
            end
         end
         repeat ($urandom_range(4, 24)) begin
            send_beat(random_beat());
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   function automatic void report_mismatch(input string what, input bus_status_type want,
                                           input bus_status_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%s: read_data %h/%h irq_mask %h/%h level1 %b/%b timer %h/%h (exp/act)",
                  what, want.read_data, got.read_data, want.irq_mask, got.irq_mask,
                  want.level1, got.level1, want.timer, got.timer);
      end
   endfunction

   always @(posedge clock) begin
      bus_status_type want;
      bus_status_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.read_data = rsp_read_data;
         got.irq_mask = rsp_irq_enable_mask;
         got.level1 = rsp_level1_pending;
         got.timer = rsp_timer_reload;
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected response beat", '0, got);
         end else begin
            want = expected_status.pop_front();
            if (got.read_data !== want.read_data || got.irq_mask !== want.irq_mask ||
                got.level1 !== want.level1 || got.timer !== want.timer) begin
               report_mismatch("response mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_memory_map();
      test_registers();
      pause_until_drained();
      test_random_traffic(1600);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
